// ===== rtl/rmv_pkg.sv =====
`default_nettype none
package rmv_pkg;

  localparam int DW = 27;
  localparam int DVW = 12;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] CFG_ZERO_CROSS  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_SENSOR_MAX  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_SENSOR_MIN  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_MOTOR_MAX   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_SAMPLE_RATE = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_PULSES_REV  = 3'd5;

  localparam logic OP_PULSE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [15:0] TALLY_MAX = 16'hFFFF;
  localparam logic [14:0] SPEED_MAX = 15'd32767;
  localparam logic [9:0] RPM_SCALE = 10'd960;

  typedef struct packed {
    logic        operation;
    logic [11:0] motor_sense_mv;
    logic [11:0] gen_sense_mv;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] motor_avg_mv;
    logic signed [15:0] gen_avg_mv;
    logic [11:0]        motor_raw_mv;
    logic [11:0]        gen_raw_mv;
    logic [14:0]        speed_avg_hz;
    logic [24:0]        rpm_avg_x16;
  } out_item_t;

  typedef struct packed {
    logic [11:0] zero_cross_mv;
    logic [11:0] sensor_max_mv;
    logic [11:0] sensor_min_mv;
    logic [14:0] motor_max_mv;
    logic [15:0] sample_rate_hz;
    logic [7:0]  rev_pulses;
  } cfg_t;

  typedef struct packed {
    logic [15:0] tally;
    logic [11:0] motor_mv;
    logic [11:0] gen_mv;
  } tick_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MOT, S_MOT_W, S_GEN, S_GEN_W, S_UPD, S_MAVG, S_MAVG_W,
    S_GAVG, S_GAVG_W, S_SAVG, S_SAVG_W, S_RPM, S_RPM_W, S_DONE
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/rmv_queue.sv =====
`default_nettype none
module rmv_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire rmv_pkg::tick_t push_data,
  output logic               full,
  output logic               pop_valid,
  input  wire logic          pop,
  output rmv_pkg::tick_t     pop_data
);
  import rmv_pkg::*;

  tick_t entries [2];
  logic wp;
  logic rp;
  logic [1:0] cnt;
  logic do_push;
  logic do_pop;

  assign full = (cnt == 2'd2);
  assign pop_valid = (cnt != 2'd0);
  assign pop_data = entries[rp];
  assign do_push = push && !full;
  assign do_pop = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      case ({do_push, do_pop})
        2'b10: cnt <= cnt + 2'd1;
        2'b01: cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rmv_front.sv =====
`default_nettype none
module rmv_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire rmv_pkg::in_item_t in_item,
  input  wire logic             q_full,
  output logic                  q_push,
  output rmv_pkg::tick_t        q_data
);
  import rmv_pkg::*;

  logic [15:0] tally;
  logic accepted;

  assign in_stall = q_full;
  assign accepted = in_valid && !in_stall;
  assign q_push = accepted && (in_item.operation == OP_TICK);
  assign q_data = '{tally: tally, motor_mv: in_item.motor_sense_mv,
                    gen_mv: in_item.gen_sense_mv};

  always_ff @(posedge clk) begin
    if (rst) begin
      tally <= '0;
    end else if (accepted) begin
      if (in_item.operation == OP_TICK) begin
        tally <= '0;
      end else if (tally != TALLY_MAX) begin
        tally <= tally + 16'd1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rmv_div.sv =====
`default_nettype none
module rmv_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [rmv_pkg::DW-1:0]   dividend,
  input  wire logic [rmv_pkg::DVW-1:0]  divisor,
  output logic                          busy,
  output logic [rmv_pkg::DW-1:0]        quotient
);
  import rmv_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DVW-1:0] rem;
  logic [DVW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic [DVW:0] shifted;
  logic take;

  assign shifted = {rem, quotient[DW-1]};
  assign take = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem <= take ? DVW'(shifted - {1'b0, dvs}) : shifted[DVW-1:0];
      quotient <= {quotient[DW-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CW'(DW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rmv_back.sv =====
`default_nettype none
module rmv_back #(
  parameter int WINDOW = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rmv_pkg::cfg_t      cfg,
  input  wire logic               q_valid,
  input  wire rmv_pkg::tick_t     q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rmv_pkg::out_item_t      out_item
);
  import rmv_pkg::*;

  localparam int SLOTW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FW = $clog2(WINDOW + 1);
  localparam int SUMW = 17 + $clog2(WINDOW);
  localparam int SSW = 16 + $clog2(WINDOW);

  back_state_t state;
  back_state_t state_next;

  tick_t ent;
  logic [SLOTW-1:0] slot;
  logic [FW-1:0] fill;
  logic signed [SUMW-1:0] mtot;
  logic signed [SUMW-1:0] gtot;
  logic [SSW-1:0] stot;
  logic signed [15:0] mring [WINDOW];
  logic signed [15:0] gring [WINDOW];
  logic [14:0] sring [WINDOW];
  logic signed [15:0] rd_m;
  logic signed [15:0] rd_g;
  logic [14:0] rd_s;
  logic signed [15:0] mv;
  logic signed [15:0] gv;
  logic [14:0] speed;
  logic msgn;
  logic mzero;
  logic mdz;
  logic signed [15:0] mavg;
  logic signed [15:0] gavg;
  logic [14:0] savg;
  logic [24:0] rpm;

  logic div_start;
  logic div_busy;
  logic [DW-1:0] div_dividend;
  logic [DVW-1:0] div_divisor;
  logic [DW-1:0] quo;

  logic [11:0] rd_sel;
  logic pos;
  logic [11:0] mag;
  logic signed [12:0] den;
  logic [11:0] dmag;
  logic [31:0] sprod;
  logic full;
  logic signed [15:0] old_m;
  logic signed [15:0] old_g;
  logic [14:0] old_s;
  logic [SUMW-1:0] mabs;
  logic [SUMW-1:0] gabs;
  logic signed [15:0] map_val;
  logic out_free;

  function automatic logic signed [15:0] map_finish(
    input logic [DW-1:0] q, input logic [14:0] lim,
    input logic sgn, input logic zero, input logic dz);
    logic [14:0] m;
    if (zero) begin
      m = '0;
    end else if (dz || (q > DW'(lim))) begin
      m = lim;
    end else begin
      m = q[14:0];
    end
    return sgn ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  rmv_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .busy(div_busy), .quotient(quo)
  );

  assign rd_sel = (state == S_GEN) ? ent.gen_mv : ent.motor_mv;
  assign pos = (rd_sel >= cfg.zero_cross_mv);
  assign mag = pos ? (rd_sel - cfg.zero_cross_mv) : (cfg.zero_cross_mv - rd_sel);
  assign den = pos ? ($signed({1'b0, cfg.sensor_max_mv}) - $signed({1'b0, cfg.zero_cross_mv}))
                   : ($signed({1'b0, cfg.zero_cross_mv}) - $signed({1'b0, cfg.sensor_min_mv}));
  assign dmag = den[12] ? 12'(-den) : den[11:0];
  assign sprod = 32'(ent.tally) * 32'(cfg.sample_rate_hz);
  assign full = (fill == FW'(WINDOW));
  assign old_m = full ? rd_m : 16'sd0;
  assign old_g = full ? rd_g : 16'sd0;
  assign old_s = full ? rd_s : 15'd0;
  assign mabs = mtot[SUMW-1] ? SUMW'(-mtot) : SUMW'(mtot);
  assign gabs = gtot[SUMW-1] ? SUMW'(-gtot) : SUMW'(gtot);
  assign map_val = map_finish(quo, cfg.motor_max_mv, msgn, mzero, mdz);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (q_valid) state_next = S_MOT;
      S_MOT:    state_next = S_MOT_W;
      S_MOT_W:  if (!div_busy) state_next = S_GEN;
      S_GEN:    state_next = S_GEN_W;
      S_GEN_W:  if (!div_busy) state_next = S_UPD;
      S_UPD:    state_next = S_MAVG;
      S_MAVG:   state_next = S_MAVG_W;
      S_MAVG_W: if (!div_busy) state_next = S_GAVG;
      S_GAVG:   state_next = S_GAVG_W;
      S_GAVG_W: if (!div_busy) state_next = S_SAVG;
      S_SAVG:   state_next = S_SAVG_W;
      S_SAVG_W: if (!div_busy) state_next = S_RPM;
      S_RPM:    state_next = S_RPM_W;
      S_RPM_W:  if (!div_busy) state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    div_start = 1'b0;
    div_dividend = '0;
    div_divisor = '0;
    unique case (state)
      S_IDLE: q_pop = q_valid;
      S_MOT, S_GEN: begin
        div_start = 1'b1;
        div_dividend = DW'(mag) * DW'(cfg.motor_max_mv);
        div_divisor = dmag;
      end
      S_MAVG: begin
        div_start = 1'b1;
        div_dividend = DW'(mabs);
        div_divisor = DVW'(fill);
      end
      S_GAVG: begin
        div_start = 1'b1;
        div_dividend = DW'(gabs);
        div_divisor = DVW'(fill);
      end
      S_SAVG: begin
        div_start = 1'b1;
        div_dividend = DW'(stot);
        div_divisor = DVW'(fill);
      end
      S_RPM: begin
        div_start = 1'b1;
        div_dividend = DW'(savg) * DW'(RPM_SCALE);
        div_divisor = (cfg.rev_pulses == 8'd0) ? DVW'(1) : DVW'(cfg.rev_pulses);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      rd_m <= mring[slot];
      rd_g <= gring[slot];
      rd_s <= sring[slot];
    end
    if (state == S_UPD) begin
      mring[slot] <= mv;
      gring[slot] <= gv;
      sring[slot] <= speed;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      ent <= q_data;
    end
    if (state == S_MOT || state == S_GEN) begin
      mzero <= (mag == 12'd0);
      mdz <= (den == 13'sd0);
      msgn <= (den == 13'sd0) ? !pos : (!pos ^ den[12]);
    end
    if (state == S_MOT) begin
      speed <= (sprod > 32'(SPEED_MAX)) ? SPEED_MAX : sprod[14:0];
    end
    if (state == S_MOT_W && !div_busy) begin
      mv <= map_val;
    end
    if (state == S_GEN_W && !div_busy) begin
      gv <= map_val;
    end
    if (state == S_MAVG_W && !div_busy) begin
      mavg <= mtot[SUMW-1] ? -$signed(quo[15:0]) : $signed(quo[15:0]);
    end
    if (state == S_GAVG_W && !div_busy) begin
      gavg <= gtot[SUMW-1] ? -$signed(quo[15:0]) : $signed(quo[15:0]);
    end
    if (state == S_SAVG_W && !div_busy) begin
      savg <= quo[14:0];
    end
    if (state == S_RPM_W && !div_busy) begin
      rpm <= quo[24:0];
    end
    if (state == S_DONE && out_free) begin
      out_item <= '{motor_avg_mv: mavg, gen_avg_mv: gavg,
                    motor_raw_mv: ent.motor_mv, gen_raw_mv: ent.gen_mv,
                    speed_avg_hz: savg, rpm_avg_x16: rpm};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot <= '0;
      fill <= '0;
      mtot <= '0;
      gtot <= '0;
      stot <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_UPD) begin
        mtot <= mtot + SUMW'(mv) - SUMW'(old_m);
        gtot <= gtot + SUMW'(gv) - SUMW'(old_g);
        stot <= stot + SSW'(speed) - SSW'(old_s);
        if (!full) begin
          fill <= fill + FW'(1);
        end
        slot <= (slot == SLOTW'(WINDOW - 1)) ? '0 : slot + SLOTW'(1);
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/motor_voltage_speed_averager.sv =====
`default_nettype none
// Motor voltage and speed averager. Speed pulse items only bump a saturating
// tally; a sample tick item is queued (two deep) and produces one result:
// six divisions run one after another on a single shared radix-2 divider,
// each one a start state, then a wait state over the divider's 27 steps (two
// voltage mappings, three window averages, rpm), plus a fetch, an update and
// an emit state. A new tick is fetched only once the previous result has been
// emitted, and pulses keep being accepted while the queue has room. Ring
// windows start empty after reset with no clearing pass; the average divides
// by the number of ticks seen until the window is full. Configuration writes
// are always accepted and should only be made while no tick is in flight.
module motor_voltage_speed_averager #(
  parameter int WINDOW = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire rmv_pkg::in_item_t            in_item,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output rmv_pkg::out_item_t                out_item,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [rmv_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [rmv_pkg::CFG_DW-1:0]   cfg_data
);
  import rmv_pkg::*;

  cfg_t cfg;
  logic q_full;
  logic q_push;
  tick_t q_in;
  logic q_valid;
  logic q_pop;
  tick_t q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{zero_cross_mv: 12'd1650, sensor_max_mv: 12'd3300,
               sensor_min_mv: 12'd0, motor_max_mv: 15'd24000,
               sample_rate_hz: 16'd100, rev_pulses: 8'd1};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ZERO_CROSS:  cfg.zero_cross_mv <= cfg_data[11:0];
        CFG_SENSOR_MAX:  cfg.sensor_max_mv <= cfg_data[11:0];
        CFG_SENSOR_MIN:  cfg.sensor_min_mv <= cfg_data[11:0];
        CFG_MOTOR_MAX:   cfg.motor_max_mv <= cfg_data[14:0];
        CFG_SAMPLE_RATE: cfg.sample_rate_hz <= cfg_data;
        CFG_PULSES_REV:  cfg.rev_pulses <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  rmv_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .q_full(q_full), .q_push(q_push), .q_data(q_in)
  );

  rmv_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_data(q_in), .full(q_full),
    .pop_valid(q_valid), .pop(q_pop), .pop_data(q_out)
  );

  rmv_back #(.WINDOW(WINDOW)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_data(q_out),
    .q_pop(q_pop), .out_valid(out_valid), .out_stall(out_stall),
    .out_item(out_item)
  );
endmodule
`default_nettype wire

// ===== tb/sv/motor_voltage_speed_averager_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module motor_voltage_speed_averager_tb;
  import rmv_pkg::*;

  localparam int RING_DEPTH = 8;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 250;
  localparam int HOLD_CYCLES = 3000;
  localparam logic [CFG_IW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  motor_voltage_speed_averager u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  in_item_t pending_items[$];
  out_item_t expected_averages[$];

  // shadow of the block
  cfg_t cfg_shadow;
  int unsigned pulse_count;
  int motor_hist[RING_DEPTH];
  int gen_hist[RING_DEPTH];
  int speed_hist[RING_DEPTH];
  int motor_sum, gen_sum, speed_sum;
  int ring_pos, ring_fill;

  int mismatches = 0;
  int items_in = 0;
  int ticks_out = 0;
  int idle_cycles = 0;
  bit in_taken = 1'b0;
  bit cfg_hit = 1'b0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int in_gap = 0;
  int stall_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [15:0] map_mv(logic [11:0] reading);
    longint zc, lim, num, den, q, rd;
    zc = cfg_shadow.zero_cross_mv;
    lim = cfg_shadow.motor_max_mv;
    rd = reading;
    num = (rd - zc) * lim;
    if (rd >= zc) den = longint'(cfg_shadow.sensor_max_mv) - zc;
    else den = zc - longint'(cfg_shadow.sensor_min_mv);
    if (den == 0) q = (num > 0) ? lim : ((num < 0) ? -lim : 0);
    else q = num / den;
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return q[15:0];
  endfunction

  task automatic apply_cfg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
    case (idx)
      CFG_ZERO_CROSS: cfg_shadow.zero_cross_mv = d[11:0];
      CFG_SENSOR_MAX: cfg_shadow.sensor_max_mv = d[11:0];
      CFG_SENSOR_MIN: cfg_shadow.sensor_min_mv = d[11:0];
      CFG_MOTOR_MAX: cfg_shadow.motor_max_mv = d[14:0];
      CFG_SAMPLE_RATE: cfg_shadow.sample_rate_hz = d;
      CFG_PULSES_REV: cfg_shadow.rev_pulses = d[7:0];
      default: ;
    endcase
  endtask

  task automatic absorb_item(in_item_t it);
    int mv, gv, speed, savg, ppr;
    longint hz;
    out_item_t res;
    if (it.operation == OP_PULSE) begin
      if (pulse_count != TALLY_MAX) pulse_count++;
    end else begin
      mv = map_mv(it.motor_sense_mv);
      gv = map_mv(it.gen_sense_mv);
      hz = longint'(pulse_count) * longint'(cfg_shadow.sample_rate_hz);
      speed = (hz > SPEED_MAX) ? SPEED_MAX : int'(hz);
      pulse_count = 0;
      motor_sum += mv - motor_hist[ring_pos];
      gen_sum += gv - gen_hist[ring_pos];
      speed_sum += speed - speed_hist[ring_pos];
      motor_hist[ring_pos] = mv;
      gen_hist[ring_pos] = gv;
      speed_hist[ring_pos] = speed;
      ring_pos = (ring_pos + 1) % RING_DEPTH;
      if (ring_fill < RING_DEPTH) ring_fill++;
      savg = speed_sum / ring_fill;
      ppr = (cfg_shadow.rev_pulses == 0) ? 1 : cfg_shadow.rev_pulses;
      res.motor_avg_mv = 16'(motor_sum / ring_fill);
      res.gen_avg_mv = 16'(gen_sum / ring_fill);
      res.motor_raw_mv = it.motor_sense_mv;
      res.gen_raw_mv = it.gen_sense_mv;
      res.speed_avg_hz = 15'(savg);
      res.rpm_avg_x16 = 25'((savg * 960) / ppr);
      expected_averages.push_back(res);
    end
  endtask

  task automatic compare_result(out_item_t got);
    out_item_t want;
    if (expected_averages.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item %h", got);
    end else begin
      want = expected_averages.pop_front();
      ticks_out++;
      if (got.motor_avg_mv !== want.motor_avg_mv || got.gen_avg_mv !== want.gen_avg_mv ||
          got.motor_raw_mv !== want.motor_raw_mv || got.gen_raw_mv !== want.gen_raw_mv ||
          got.speed_avg_hz !== want.speed_avg_hz || got.rpm_avg_x16 !== want.rpm_avg_x16) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch tick %0d: exp m=%0d g=%0d mr=%0d gr=%0d s=%0d r=%0d",
            ticks_out, want.motor_avg_mv, want.gen_avg_mv, want.motor_raw_mv,
            want.gen_raw_mv, want.speed_avg_hz, want.rpm_avg_x16);
          $display("  got m=%0d g=%0d mr=%0d gr=%0d s=%0d r=%0d",
            got.motor_avg_mv, got.gen_avg_mv, got.motor_raw_mv,
            got.gen_raw_mv, got.speed_avg_hz, got.rpm_avg_x16);
        end
      end
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      stall_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      out_stall <= 1'b0;
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      in_taken <= in_valid && !in_stall;
      cfg_hit <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        items_in++;
        absorb_item(in_item);
      end
      if (out_valid && !out_stall) compare_result(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IW-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value[CFG_DW-1:0];
    do @(negedge clk); while (!cfg_hit);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(int unsigned zc, int unsigned smax, int unsigned smin,
                           int unsigned mmax, int unsigned rate, int unsigned ppr);
    write_reg(CFG_ZERO_CROSS, zc);
    write_reg(CFG_SENSOR_MAX, smax);
    write_reg(CFG_SENSOR_MIN, smin);
    write_reg(CFG_MOTOR_MAX, mmax);
    write_reg(CFG_SAMPLE_RATE, rate);
    write_reg(CFG_PULSES_REV, ppr);
  endtask

  task automatic push_tick(logic [11:0] m, logic [11:0] g);
    in_item_t it;
    it.operation = OP_TICK;
    it.motor_sense_mv = m;
    it.gen_sense_mv = g;
    pending_items.push_back(it);
  endtask

  task automatic push_pulses(int n);
    in_item_t it;
    repeat (n) begin
      it.operation = OP_PULSE;
      it.motor_sense_mv = 12'($urandom);
      it.gen_sense_mv = 12'($urandom);
      pending_items.push_back(it);
    end
  endtask

  task automatic settle();
    wait (pending_items.size() == 0 && !in_valid && expected_averages.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int unsigned pick_mv();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 4095;
    if (r == 2) return cfg_shadow.zero_cross_mv;
    return $urandom_range(0, 4095);
  endfunction

  function automatic int unsigned pick_cfg(int unsigned top);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 0;
    if (r == 1) return top;
    return $urandom_range(0, top);
  endfunction

  task automatic random_phase(int n_items);
    int made, np;
    made = 0;
    while (made < n_items) begin
      np = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 400) : $urandom_range(0, 6);
      push_pulses(np);
      push_tick(12'(pick_mv()), 12'(pick_mv()));
      made += np + 1;
    end
  endtask

  initial begin
    cfg_shadow = '{zero_cross_mv: 12'd1650, sensor_max_mv: 12'd3300, sensor_min_mv: 12'd0,
                   motor_max_mv: 15'd24000, sample_rate_hz: 16'd100, rev_pulses: 8'd1};
    pulse_count = 0;
    motor_sum = 0;
    gen_sum = 0;
    speed_sum = 0;
    ring_pos = 0;
    ring_fill = 0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      motor_hist[i] = 0;
      gen_hist[i] = 0;
      speed_hist[i] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: extremes and zero cross
    push_tick(12'd0, 12'd4095);
    push_tick(12'd1650, 12'd1650);
    push_pulses(3);
    push_tick(12'd4095, 12'd0);
    push_pulses(1);
    push_tick(12'd3300, 12'd1);
    settle();

    // zero denominators, fastest rate, zero pulses per rev, unknown indexes
    write_all(2000, 2000, 2000, 32767, 65535, 0);
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'h1234);
    push_tick(12'd2000, 12'd0);
    push_tick(12'd4095, 12'd2000);
    push_pulses(2);
    push_tick(12'd0, 12'd4095);
    settle();

    // reversed limits, zero motor max, zero rate
    write_all(1000, 500, 3000, 0, 0, 255);
    push_pulses(5);
    push_tick(12'd4095, 12'd0);
    settle();
    write_reg(CFG_MOTOR_MAX, 16'h7FFF);
    push_tick(12'd0, 12'd4095);
    push_tick(12'd999, 12'd1001);
    settle();

    // speed saturation
    write_all(4095, 4095, 0, 24000, 200, 255);
    push_pulses(300);
    push_tick(12'd4095, 12'd0);
    push_tick(12'd4094, 12'd1);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) write_all(1650, 3300, 0, 24000, 100, 1);
      else write_all(pick_cfg(4095), pick_cfg(4095), pick_cfg(4095),
                     pick_cfg(32767), ($urandom_range(0, 3) == 0) ? pick_cfg(65535)
                     : $urandom_range(1, 300), pick_cfg(255));
      no_idle = (ph == 3);
      if (ph == 2) hold_req = 1'b1;
      random_phase(270);
      settle();
    end

    $display("run covered %0d input items and %0d tick results over reset, extreme,",
             items_in, ticks_out);
    $display("reversed, zero-denominator and random settings with speed saturation");
    if (mismatches == 0 && expected_averages.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_averages.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== motor_voltage_speed_averager.f =====
rtl/rmv_pkg.sv
rtl/rmv_queue.sv
rtl/rmv_front.sv
rtl/rmv_div.sv
rtl/rmv_back.sv
rtl/motor_voltage_speed_averager.sv
tb/sv/motor_voltage_speed_averager_tb.sv
